[rtl/ses_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ses_pkg
// shared types and constants of the symmetric exponential smoother
// ----------------------------------------------------------------------------
package ses_pkg;

    // payload and register widths
    localparam int COORD_W     = 32;
    localparam int WEIGHT_W    = 17;
    localparam int RATIO_W     = 16;
    localparam int CFG_WIDTH_W = 5;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // window half-width is this many times the smoothing width
    localparam int WINDOW_FACTOR = 3;

    // default sizing
    localparam int DEFAULT_MAX_WIDTH     = 16;
    localparam int DEFAULT_HISTORY_DEPTH = 128;

    // weight arithmetic: weights in q1.16, decay ratio and rounding half in q0.16
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam logic [RATIO_W-1:0]  ROUND_HALF = 16'd32768;

    // register reset values
    localparam logic [CFG_WIDTH_W-1:0] WIDTH_INDEX_RESET = 5'd4;
    localparam logic [RATIO_W-1:0]     DECAY_RATIO_RESET = 16'd54744;

    // configuration register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WIDTH_INDEX = 1'b0,
        REG_DECAY_RATIO = 1'b1
    } cfg_reg_t;

    // main sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SETUP,
        ST_TAP,
        ST_DRAIN,
        ST_DIV,
        ST_EMIT
    } seq_state_t;

    // divider sequencer
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_PREP,
        DV_RUN,
        DV_SIGN
    } div_state_t;

endpackage

[rtl/ses_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ses_ram
// generic single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
module ses_ram
    import ses_pkg::*;
#(
    parameter int  WIDTH  = COORD_W,
    parameter int  DEPTH  = DEFAULT_HISTORY_DEPTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/ses_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ses_div
// bit-serial signed divide, rounding to nearest with ties away from zero
// ----------------------------------------------------------------------------
module ses_div
    import ses_pkg::*;
#(
    parameter int ACC_W  = COORD_W + WEIGHT_W + $clog2(2 * WINDOW_FACTOR * DEFAULT_MAX_WIDTH + 1),
    parameter int WSUM_W = WEIGHT_W + $clog2(2 * WINDOW_FACTOR * DEFAULT_MAX_WIDTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] num,
    input  logic [WSUM_W-1:0]       den,
    output logic                    done,
    output logic [COORD_W-1:0]      quot
);

    localparam int CNT_W = $clog2(COORD_W);

    div_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic                sign_reg;
    logic [ACC_W-1:0]    mag_reg;
    logic [WSUM_W-1:0]   den_reg;
    logic [WSUM_W-1:0]   rem_reg;
    logic [COORD_W-1:0]  low_reg;
    logic [COORD_W-1:0]  quot_reg;
    logic                done_reg;

    logic [ACC_W-1:0]    mag_calc;
    logic [ACC_W-1:0]    biased;
    logic [WSUM_W:0]     trial;
    logic [WSUM_W:0]     trial_sub;
    logic                trial_ge;
    logic                last_step;

    // magnitude, then half the divisor added for round to nearest
    assign mag_calc  = num[ACC_W-1] ? (~$unsigned(num) + ACC_W'(1)) : $unsigned(num);
    assign biased    = mag_reg + ACC_W'(den_reg >> 1);
    assign trial     = {rem_reg, low_reg[COORD_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign trial_ge  = (trial >= {1'b0, den_reg});
    assign last_step = (cnt_reg == CNT_W'(COORD_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == DV_SIGN);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    state_next = DV_PREP;
                end
            end
            DV_PREP: begin
                state_next = DV_RUN;
            end
            DV_RUN: begin
                if (last_step) begin
                    state_next = DV_SIGN;
                end
            end
            DV_SIGN: begin
                state_next = DV_IDLE;
            end
            default: begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    sign_reg <= num[ACC_W-1];
                    mag_reg  <= mag_calc;
                    den_reg  <= den;
                end
            end
            DV_PREP: begin
                // quotient fits 32 bits, so the upper part is already below den
                rem_reg <= biased[ACC_W-1:COORD_W];
                low_reg <= biased[COORD_W-1:0];
                cnt_reg <= '0;
            end
            DV_RUN: begin
                rem_reg <= trial_ge ? trial_sub[WSUM_W-1:0] : trial[WSUM_W-1:0];
                low_reg <= {low_reg[COORD_W-2:0], trial_ge};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            DV_SIGN: begin
                quot_reg <= sign_reg ? (~low_reg + COORD_W'(1)) : low_reg;
            end
            default: begin
            end
        endcase
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[rtl/symmetric_exponential_smoother_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_exponential_smoother_unit
// smooths a 2-d point trajectory with symmetric exponentially weighted windows
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one raw point a beat (x, y, last flag). m_ channel: smoothed
//   points in index order, last_out set on the point of the final sample.
//   cfg channel: width_index (index 0) and decay_ratio (index 1), always
//   ready; write only while the block is idle.
// timing
//   point i is produced once sample i+3w has arrived; a beat marked last
//   flushes all pending points. for each point (window half-width at most
//   3w) the taps share one read port of the history rams, one read for the
//   center tap and two for each other tap, and the divider retires one
//   quotient bit a cycle. a beat produces no point while the window fills,
//   one point in steady state, and up to 3w+1 points when it is the last.
//   one beat is worked at a time; s_ready is high only between beats.
// reset
//   aresetn clears the sample counters and restores the register defaults;
//   history contents stay undefined until written.
// stall
//   results leave through an output register; a new beat is taken while it
//   still waits, and the next point waits for it to drain.
// ----------------------------------------------------------------------------
module symmetric_exponential_smoother_unit
    import ses_pkg::*;
#(
    parameter int MAX_WIDTH     = DEFAULT_MAX_WIDTH,
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [COORD_W-1:0] s_x_sample,
    input  logic signed [COORD_W-1:0] s_y_sample,
    input  logic                      s_last_in,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_smooth_x,
    output logic signed [COORD_W-1:0] m_smooth_y,
    output logic                      m_last_out
);

    localparam int WIN_MAX = WINDOW_FACTOR * MAX_WIDTH;
    localparam int TAP_W   = $clog2(WIN_MAX + 1);
    localparam int RES_MAX = WIN_MAX + 1;
    localparam int CNT_W   = $clog2(RES_MAX + 1);
    localparam int WSUM_W  = WEIGHT_W + $clog2(2 * WIN_MAX + 1);
    localparam int ACC_W   = COORD_W + WSUM_W;
    localparam int PROD_W  = COORD_W + WEIGHT_W + 1;
    localparam int ADDR_W  = $clog2(HISTORY_DEPTH);
    localparam int WP_W    = WEIGHT_W + RATIO_W;

    // configuration
    logic [CFG_WIDTH_W-1:0] width_index_reg;
    logic [RATIO_W-1:0]     decay_ratio_reg;
    logic [CFG_WIDTH_W-1:0] w_eff;
    logic [TAP_W-1:0]       w3_calc;

    // sequencer and counters
    seq_state_t             state_reg, state_next;
    logic [COORD_W-1:0]     samples_seen_reg;
    logic [COORD_W-1:0]     next_idx_reg;
    logic [ADDR_W-1:0]      wr_ptr_reg;
    logic [ADDR_W-1:0]      base_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   last_reg;
    logic [TAP_W-1:0]       w3_reg;

    // tap walk
    logic [TAP_W-1:0]       h_reg;
    logic [TAP_W-1:0]       tap_reg;
    logic                   side_reg;
    logic [ADDR_W-1:0]      pa_reg;
    logic [ADDR_W-1:0]      pb_reg;
    logic [WEIGHT_W-1:0]    wt_reg;
    logic [WSUM_W-1:0]      wsum_reg;

    // multiply-accumulate pipe
    logic                   v1_reg;
    logic [WEIGHT_W-1:0]    wt1_reg;
    logic                   v2_reg;
    logic signed [PROD_W-1:0] prod_x_reg;
    logic signed [PROD_W-1:0] prod_y_reg;
    logic signed [ACC_W-1:0]  acc_x_reg;
    logic signed [ACC_W-1:0]  acc_y_reg;

    // output register
    logic                   m_valid_reg;
    logic [COORD_W-1:0]     m_x_reg;
    logic [COORD_W-1:0]     m_y_reg;
    logic                   m_last_reg;

    // combinational helpers
    logic                   accept;
    logic                   cfg_write;
    logic [COORD_W-1:0]     pending;
    logic                   more;
    logic [COORD_W-1:0]     h_wide;
    logic [TAP_W-1:0]       h_calc;
    logic                   tap_final;
    logic                   drain_done;
    logic                   out_free;
    logic                   emit;
    logic                   flush_end;
    logic                   div_start;
    logic                   div_done_x;
    logic                   div_done_y;
    logic [COORD_W-1:0]     quot_x;
    logic [COORD_W-1:0]     quot_y;
    logic [WP_W-1:0]        wt_prod;
    logic [COORD_W-1:0]     x_rdata;
    logic [COORD_W-1:0]     y_rdata;
    logic [ADDR_W-1:0]      raddr;
    logic [COORD_W-1:0]     next_idx_inc;
    logic [COORD_W-1:0]     samples_inc;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_index_reg <= WIDTH_INDEX_RESET;
            decay_ratio_reg <= DECAY_RATIO_RESET;
        end else if (cfg_write) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WIDTH_INDEX: width_index_reg <= cfg_data[CFG_WIDTH_W-1:0];
                REG_DECAY_RATIO: decay_ratio_reg <= cfg_data[RATIO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // width saturated to 1..MAX_WIDTH, window half-width 3w
    always_comb begin
        if (width_index_reg == '0) begin
            w_eff = CFG_WIDTH_W'(1);
        end else if (width_index_reg > CFG_WIDTH_W'(MAX_WIDTH)) begin
            w_eff = CFG_WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = width_index_reg;
        end
    end

    assign w3_calc = TAP_W'(WINDOW_FACTOR * int'(w_eff));

    // ------------------------------------------------------------------
    // history rams, written at accept, one tap read a cycle
    // ------------------------------------------------------------------
    assign raddr = side_reg ? pb_reg : pa_reg;

    ses_ram #(
        .WIDTH (COORD_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_x_ram (
        .aclk  (aclk),
        .we    (accept),
        .waddr (wr_ptr_reg),
        .wdata (s_x_sample),
        .raddr (raddr),
        .rdata (x_rdata)
    );

    ses_ram #(
        .WIDTH (COORD_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_y_ram (
        .aclk  (aclk),
        .we    (accept),
        .waddr (wr_ptr_reg),
        .wdata (s_y_sample),
        .raddr (raddr),
        .rdata (y_rdata)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign accept       = s_valid && s_ready;
    assign pending      = samples_seen_reg + COORD_W'(1) - next_idx_reg;
    assign more         = (count_reg < CNT_W'(RES_MAX)) &&
                          (last_reg ? (pending != '0)
                                    : (pending > COORD_W'(w3_reg)));
    assign tap_final    = (tap_reg == h_reg) && (side_reg || (tap_reg == '0));
    assign drain_done   = !v1_reg && !v2_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign emit         = (state_reg == ST_EMIT) && out_free;
    assign flush_end    = (state_reg == ST_CHECK) && !more && last_reg;
    assign div_start    = (state_reg == ST_DRAIN) && drain_done;
    assign next_idx_inc = next_idx_reg + COORD_W'(1);
    assign samples_inc  = samples_seen_reg + COORD_W'(1);

    // h = min(3w, i-1, n-i on a flush)
    always_comb begin
        h_wide = COORD_W'(w3_reg);
        if ((next_idx_reg - COORD_W'(1)) < h_wide) begin
            h_wide = next_idx_reg - COORD_W'(1);
        end
        if (last_reg && ((samples_seen_reg - next_idx_reg) < h_wide)) begin
            h_wide = samples_seen_reg - next_idx_reg;
        end
        h_calc = h_wide[TAP_W-1:0];
    end

    // next weight: w(d) = (w(d-1) * r + 0.5) >> 16
    assign wt_prod = WP_W'(wt_reg) * WP_W'(decay_ratio_reg) + WP_W'(ROUND_HALF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = more ? ST_SETUP : ST_IDLE;
            end
            ST_SETUP: begin
                state_next = ST_TAP;
            end
            ST_TAP: begin
                if (tap_final) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done_x) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_CHECK;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // counters and pipe valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_seen_reg <= '0;
            next_idx_reg     <= COORD_W'(1);
            wr_ptr_reg       <= '0;
            base_reg         <= '0;
            count_reg        <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            v1_reg <= (state_reg == ST_TAP);
            v2_reg <= v1_reg;

            if (accept) begin
                samples_seen_reg <= samples_inc;
                count_reg        <= '0;
                // ring slot follows samples_seen mod depth, also across a wrap
                if (samples_inc == '0 || wr_ptr_reg == ADDR_W'(HISTORY_DEPTH - 1)) begin
                    wr_ptr_reg <= '0;
                end else begin
                    wr_ptr_reg <= wr_ptr_reg + ADDR_W'(1);
                end
            end else if (flush_end) begin
                samples_seen_reg <= '0;
                wr_ptr_reg       <= '0;
            end

            if (emit) begin
                next_idx_reg <= next_idx_inc;
                count_reg    <= count_reg + CNT_W'(1);
                if (next_idx_inc == COORD_W'(1) ||
                    base_reg == ADDR_W'(HISTORY_DEPTH - 1)) begin
                    base_reg <= '0;
                end else begin
                    base_reg <= base_reg + ADDR_W'(1);
                end
            end else if (flush_end) begin
                next_idx_reg <= COORD_W'(1);
                base_reg     <= '0;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg <= s_last_in;
            w3_reg   <= w3_calc;
        end

        if (state_reg == ST_SETUP) begin
            h_reg    <= h_calc;
            tap_reg  <= '0;
            side_reg <= 1'b0;
            pa_reg   <= base_reg;
            pb_reg   <= base_reg;
            wt_reg   <= WEIGHT_ONE;
            wsum_reg <= '0;
        end else if (state_reg == ST_TAP) begin
            wsum_reg <= wsum_reg + WSUM_W'(wt_reg);
            if (!tap_final) begin
                if (side_reg || tap_reg == '0) begin
                    // step to the next distance on both sides of the center
                    tap_reg  <= tap_reg + TAP_W'(1);
                    side_reg <= 1'b0;
                    wt_reg   <= wt_prod[WP_W-1:RATIO_W];
                    pa_reg   <= (pa_reg == ADDR_W'(HISTORY_DEPTH - 1)) ?
                                '0 : pa_reg + ADDR_W'(1);
                    pb_reg   <= (pb_reg == '0) ?
                                ADDR_W'(HISTORY_DEPTH - 1) : pb_reg - ADDR_W'(1);
                end else begin
                    side_reg <= 1'b1;
                end
            end
        end

        // ram read data is registered and arrives in the cycle after its address
        wt1_reg    <= wt_reg;
        prod_x_reg <= PROD_W'($signed(x_rdata) * $signed({1'b0, wt1_reg}));
        prod_y_reg <= PROD_W'($signed(y_rdata) * $signed({1'b0, wt1_reg}));

        if (state_reg == ST_SETUP) begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end else if (v2_reg) begin
            acc_x_reg <= acc_x_reg + ACC_W'(prod_x_reg);
            acc_y_reg <= acc_y_reg + ACC_W'(prod_y_reg);
        end

        if (emit) begin
            m_x_reg    <= quot_x;
            m_y_reg    <= quot_y;
            m_last_reg <= last_reg && (next_idx_reg == samples_seen_reg);
        end
    end

    // ------------------------------------------------------------------
    // dividers, one per coordinate, started together
    // ------------------------------------------------------------------
    ses_div #(
        .ACC_W  (ACC_W),
        .WSUM_W (WSUM_W)
    ) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_x_reg),
        .den     (wsum_reg),
        .done    (div_done_x),
        .quot    (quot_x)
    );

    ses_div #(
        .ACC_W  (ACC_W),
        .WSUM_W (WSUM_W)
    ) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_y_reg),
        .den     (wsum_reg),
        .done    (div_done_y),
        .quot    (quot_y)
    );

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign m_valid    = m_valid_reg;
    assign m_smooth_x = $signed(m_x_reg);
    assign m_smooth_y = $signed(m_y_reg);
    assign m_last_out = m_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(RES_MAX))
        else $error("more results from one beat than the window allows");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_end |=> (samples_seen_reg == '0) && (next_idx_reg == COORD_W'(1)))
        else $error("counters not rewound after the last beat");

    a_wsum_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (wsum_reg >= WSUM_W'(WEIGHT_ONE)))
        else $error("weight sum below one at divide start");

    a_tap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAP) |-> (tap_reg <= h_reg))
        else $error("tap walk ran past the window");

    a_div_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_done_x || div_done_y) |-> (div_done_x && div_done_y &&
                                         (state_reg == ST_DIV)))
        else $error("divider completion out of step");

endmodule

[tb/sv/tb_symmetric_exponential_smoother_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_symmetric_exponential_smoother_unit
// self-checking bench for the symmetric exponential trajectory smoother
// ----------------------------------------------------------------------------
// raw points go in through the s_ channel. Every accepted beat runs through
// an in-bench smoother that keeps its own history rings, counters and weight
// table. The smoothed points it predicts are queued. A checker pops one
// point for each m_ beat and compares it field by field. Directed trajectories
// come first: single points, extremes, width saturation, a width change mid
// trajectory. Then come output back-pressure, a full 49-point flush and random
// trajectories under random register settings. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_symmetric_exponential_smoother_unit;
    import ses_pkg::*;

    // sizing of the in-bench smoother, matching the block defaults
    localparam int MAX_W        = DEFAULT_MAX_WIDTH;
    localparam int HIST_DEPTH   = DEFAULT_HISTORY_DEPTH;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int MAX_TAP      = WINDOW_FACTOR * MAX_W;
    localparam int MAX_POINTS   = MAX_TAP + 1;

    // long enough for any point still in flight to finish
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 25000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_ITEMS   = 40;
    localparam int FLUSH_ITEMS   = 60;
    localparam int RANDOM_ITEMS  = 306;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } point_t;

    // ports
    logic                      aclk       = 1'b0;
    logic                      aresetn    = 1'b0;
    logic                      cfg_valid  = 1'b0;
    logic                      cfg_ready;
    cfg_reg_t                  cfg_index  = REG_WIDTH_INDEX;
    logic [CFG_DATA_W-1:0]     cfg_data   = '0;
    logic                      s_valid    = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_x_sample = '0;
    logic signed [COORD_W-1:0] s_y_sample = '0;
    logic                      s_last_in  = 1'b0;
    logic                      m_valid;
    logic                      m_ready    = 1'b0;
    logic signed [COORD_W-1:0] m_smooth_x;
    logic signed [COORD_W-1:0] m_smooth_y;
    logic                      m_last_out;

    // in-bench smoother state
    logic [CFG_WIDTH_W-1:0] width_reg;
    logic [RATIO_W-1:0]     ratio_reg;
    logic [COORD_W-1:0]     hist_x [HIST_DEPTH];
    logic [COORD_W-1:0]     hist_y [HIST_DEPTH];
    logic [31:0]            seen_cnt;
    logic [31:0]            next_idx;
    longint                 tap_wt [0:MAX_TAP];

    // smoothed points still to come out of the block
    point_t pending_points [$];
    point_t oldest_point;

    // bench control
    int  err_count     = 0;
    int  cycle_count   = 0;
    int  results_taken = 0;
    int  taken_seen    = 0;
    int  stall_left    = 0;
    int  hold_left     = 0;
    bit  no_idle       = 1'b0;
    logic [COORD_W-1:0] walk_x = '0;
    logic [COORD_W-1:0] walk_y = '0;

    symmetric_exponential_smoother_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_x_sample (s_x_sample),
        .s_y_sample (s_y_sample),
        .s_last_in  (s_last_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_smooth_x (m_smooth_x),
        .m_smooth_y (m_smooth_y),
        .m_last_out (m_last_out)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[symmetric_exponential_smoother_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // in-bench smoother
    // ------------------------------------------------------------------------

    // signed quotient, rounded to nearest, ties away from zero
    function automatic logic [COORD_W-1:0] round_quot(input longint num,
                                                      input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        logic [63:0]     r;
        mag = (num < 0) ? (64'd0 - 64'(num)) : 64'(num);
        q   = (mag + den / 2) / den;
        r   = (num < 0) ? (64'd0 - q) : q;
        return r[COORD_W-1:0];
    endfunction

    // weighted mean around point i; on a flush n is the trajectory length
    function automatic point_t smooth_point(input logic [31:0] i, input bit flush,
                                            input logic [31:0] n, input logic [31:0] w3);
        point_t            p;
        logic [31:0]       h;
        logic [31:0]       ka;
        logic [31:0]       kb;
        longint            sx;
        longint            sy;
        longint unsigned   wsum;
        h    = w3;
        sx   = 0;
        sy   = 0;
        wsum = 0;
        // window shrinks at both ends of the trajectory
        if (i - 32'd1 < h) h = i - 32'd1;
        if (flush && (n - i < h)) h = n - i;
        for (int d = 0; d <= h; d++) begin
            ka = i - 32'd1 + d;
            kb = i - 32'd1 - d;
            sx   += longint'($signed(hist_x[HIST_AW'(ka % HIST_DEPTH)])) * tap_wt[d];
            sy   += longint'($signed(hist_y[HIST_AW'(ka % HIST_DEPTH)])) * tap_wt[d];
            wsum += tap_wt[d];
            if (d != 0) begin
                sx   += longint'($signed(hist_x[HIST_AW'(kb % HIST_DEPTH)])) * tap_wt[d];
                sy   += longint'($signed(hist_y[HIST_AW'(kb % HIST_DEPTH)])) * tap_wt[d];
                wsum += tap_wt[d];
            end
        end
        p.x    = round_quot(sx, wsum);
        p.y    = round_quot(sy, wsum);
        p.last = flush && (i == n);
        return p;
    endfunction

    // one accepted raw point: store it and queue every point it releases
    task automatic predict_beat(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic last);
        logic [31:0] w;
        logic [31:0] w3;
        logic [31:0] backlog;
        int          count;
        w = 32'(width_reg);
        if (w < 32'd1) w = 32'd1;
        if (w > 32'(MAX_W)) w = 32'(MAX_W);
        w3 = 32'(WINDOW_FACTOR) * w;
        count = 0;
        tap_wt[0] = 65536;
        for (int d = 1; d <= MAX_TAP; d++)
            tap_wt[d] = (tap_wt[d-1] * longint'(ratio_reg) + 32768) >>> 16;
        seen_cnt += 32'd1;
        hist_x[HIST_AW'((seen_cnt - 32'd1) % HIST_DEPTH)] = x;
        hist_y[HIST_AW'((seen_cnt - 32'd1) % HIST_DEPTH)] = y;
        backlog = seen_cnt + 32'd1 - next_idx;
        if (!last) begin
            // a point is ready once 3w samples past it are in
            while (count < MAX_POINTS && backlog > w3) begin
                pending_points.insert(pending_points.size(),
                                      smooth_point(next_idx, 1'b0, 32'd0, w3));
                next_idx += 32'd1;
                count++;
                backlog = seen_cnt + 32'd1 - next_idx;
            end
        end else begin
            // the last sample releases everything still held
            while (count < MAX_POINTS && backlog != 32'd0) begin
                pending_points.insert(pending_points.size(),
                                      smooth_point(next_idx, 1'b1, seen_cnt, w3));
                next_idx += 32'd1;
                count++;
                backlog = seen_cnt + 32'd1 - next_idx;
            end
            seen_cnt = 32'd0;
            next_idx = 32'd1;
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // every m_ beat against the oldest predicted point
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_taken++;
            if (pending_points.size() == 0) begin
                $error("unexpected smoothed point x=%0d y=%0d last=%0b",
                       m_smooth_x, m_smooth_y, m_last_out);
                err_count++;
            end else begin
                oldest_point = pending_points.pop_front();
                if (m_smooth_x !== oldest_point.x) begin
                    $error("smooth_x mismatch: expected %0d, actual %0d",
                           oldest_point.x, m_smooth_x);
                    err_count++;
                end
                if (m_smooth_y !== oldest_point.y) begin
                    $error("smooth_y mismatch: expected %0d, actual %0d",
                           oldest_point.y, m_smooth_y);
                    err_count++;
                end
                if (m_last_out !== oldest_point.last) begin
                    $error("last_out mismatch: expected %0b, actual %0b",
                           oldest_point.last, m_last_out);
                    err_count++;
                end
            end
        end
    end

    // receiver: a random pause after each beat, plus a long hold on request
    always @(negedge aclk) begin
        if (results_taken != taken_seen) begin
            taken_seen = results_taken;
            stall_left = no_idle ? 0 : $urandom_range(0, 5);
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // one raw point; valid stays up after the beat so a gap-free next point
    // follows directly, end_input drops it
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_x_sample <= x;
        s_y_sample <= y;
        s_last_in  <= last;
        do @(posedge aclk); while (!s_ready);
        predict_beat(x, y, last);
    endtask

    task automatic end_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // sender quiet until every predicted point is out and the block is idle
    task automatic drain_results();
        end_input();
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_WIDTH_INDEX: width_reg = data[CFG_WIDTH_W-1:0];
            REG_DECAY_RATIO: ratio_reg = data[RATIO_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mix of full-range values, extremes and a slow walk
    function automatic logic [COORD_W-1:0] next_coord(input logic [COORD_W-1:0] prev);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return $urandom;
        if (sel == 4) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return prev + ($urandom_range(0, 4095) - 2048);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // trajectories of one point under the reset settings
    task automatic test_single_point();
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    endtask

    // full-scale swings with the flattest and the steepest decay
    task automatic test_extremes();
        drain_results();
        write_reg(REG_WIDTH_INDEX, 16'd1);
        write_reg(REG_DECAY_RATIO, 16'hFFFF);
        for (int k = 0; k < 3; k++)
            send_point((k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                       (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000, k == 2);
        drain_results();
        write_reg(REG_DECAY_RATIO, 16'h0000);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    endtask

    // width 0 counts as 1, widths past the maximum saturate
    task automatic test_width_saturation();
        drain_results();
        write_reg(REG_WIDTH_INDEX, 16'd0);
        write_reg(REG_DECAY_RATIO, DECAY_RATIO_RESET);
        for (int k = 1; k <= 4; k++)
            send_point(k * 1000, -k * 3000, k == 4);
        drain_results();
        write_reg(REG_WIDTH_INDEX, 16'hFFF1);
        for (int k = 1; k <= 3; k++)
            send_point($urandom, $urandom, k == 3);
    endtask

    // width drops while a trajectory is open; sender waits for all results
    task automatic test_mid_trajectory_width();
        drain_results();
        write_reg(REG_WIDTH_INDEX, 16'd2);
        write_reg(REG_DECAY_RATIO, 16'd40000);
        for (int k = 1; k <= 7; k++)
            send_point(k * 77777, 32'h4000_0000 - k * 99999, 1'b0);
        drain_results();
        write_reg(REG_WIDTH_INDEX, 16'd1);
        send_point(32'h1234_5678, 32'hEDCB_A987, 1'b0);
        send_point(32'h7FFF_0000, 32'h8000_FFFF, 1'b0);
        send_point(32'h0000_0001, 32'hFFFF_FFFE, 1'b1);
    endtask

    // receiver holds off for a long stretch while points keep coming
    task automatic test_output_backpressure();
        drain_results();
        write_reg(REG_WIDTH_INDEX, 16'd1);
        write_reg(REG_DECAY_RATIO, 16'd30000);
        hold_left = HOLD_CYCLES;
        for (int k = 1; k <= STALL_ITEMS; k++) begin
            walk_x = next_coord(walk_x);
            walk_y = next_coord(walk_y);
            send_point(walk_x, walk_y, k == STALL_ITEMS);
        end
    endtask

    // widest window, trajectory long enough that the last beat flushes 49
    task automatic test_full_flush();
        drain_results();
        write_reg(REG_WIDTH_INDEX, 16'd31);
        write_reg(REG_DECAY_RATIO, 16'hFFFF);
        for (int k = 1; k <= FLUSH_ITEMS; k++) begin
            walk_x = next_coord(walk_x);
            walk_y = next_coord(walk_y);
            send_point(walk_x, walk_y, k == FLUSH_ITEMS);
        end
    endtask

    // random trajectories, settings changed between them
    task automatic test_random_trajectories();
        int          sent;
        int          len;
        int unsigned pick;
        logic [4:0]  w;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 1) begin
                drain_results();
                w = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(1, 4));
                // upper data bits are don't-care for the width register
                write_reg(REG_WIDTH_INDEX, {11'($urandom_range(0, 2047)), w});
                case ($urandom_range(0, 3))
                    0:       write_reg(REG_DECAY_RATIO, $urandom_range(0, 1) ? 16'hFFFF : 16'h0);
                    1:       write_reg(REG_DECAY_RATIO, 16'($urandom_range(0, 65535)));
                    default: write_reg(REG_DECAY_RATIO, 16'($urandom_range(40000, 65535)));
                endcase
            end
            no_idle = ($urandom_range(0, 5) == 0);
            // mostly short, now and then long enough to wrap the history ring
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = $urandom_range(130, 200);
            else if (pick < 4)
                len = $urandom_range(40, 80);
            else
                len = $urandom_range(1, 20);
            for (int k = 1; k <= len; k++) begin
                walk_x = next_coord(walk_x);
                walk_y = next_coord(walk_y);
                send_point(walk_x, walk_y, k == len);
                sent++;
                if (k != len && $urandom_range(0, 99) == 0)
                    drain_results();
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        // in-bench smoother starts in its reset state
        width_reg = WIDTH_INDEX_RESET;
        ratio_reg = DECAY_RATIO_RESET;
        seen_cnt  = 32'd0;
        next_idx  = 32'd1;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_x[k] = '0;
            hist_y[k] = '0;
        end

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_single_point();
        test_extremes();
        test_width_saturation();
        test_mid_trajectory_width();
        test_output_backpressure();
        test_full_flush();
        test_random_trajectories();
        drain_results();

        if (err_count == 0) begin
            $display("[symmetric_exponential_smoother_unit] OK");
        end else begin
            $display("[symmetric_exponential_smoother_unit] ERROR");
        end
        $finish;
    end

endmodule
